// ===== design/windowed_nearest_point_search_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Windowed nearest point search: assertion macros
// Concurrent checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_NEAREST_POINT_SEARCH_UNIT_MACROS_SVH
`define WINDOWED_NEAREST_POINT_SEARCH_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define WNPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define WNPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WNPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define WNPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/wnps_pkg.sv =====
// ----------------------------------------------------------------------------
// Windowed nearest point search: package
// Field widths, register indexes, function codes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wnps_pkg;

    localparam int INDEX_W  = 10;
    localparam int COORD_W  = 32;
    localparam int COUNT_W  = 11;
    localparam int WINDOW_W = 34;
    localparam int GROW_W   = WINDOW_W + 3;
    localparam int PASSES_W = 4;
    localparam int DIST_W   = 32;
    localparam int SQ_W     = 2 * DIST_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int ADDR_SLOTS     = 1 << INDEX_W;

    localparam logic [COUNT_W-1:0]    POINT_COUNT_RST  = '0;
    localparam logic [COORD_W-1:0]    START_WINDOW_RST = 32'd3000000000;
    localparam logic                  USE_THIRD_RST    = 1'b1;
    localparam logic [WINDOW_W-1:0]   WINDOW_SAT       = 34'h2_0000_0000;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic [INDEX_W-1:0]          index_t;
    typedef logic signed [COORD_W-1:0]   coord_t;
    typedef logic [PASSES_W-1:0]         passes_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINT_COUNT    = 2'd0,
        REG_START_WINDOW   = 2'd1,
        REG_USE_THIRD_AXIS = 2'd2
    } cfg_reg_t;

endpackage

// ===== design/wnps_if.sv =====
// ----------------------------------------------------------------------------
// Windowed nearest point search: channel interfaces
// Item, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wnps_item_if;
    logic                  valid;
    logic                  ready;
    logic                  func;
    wnps_pkg::index_t      entry_index;
    wnps_pkg::coord_t      coord_x;
    wnps_pkg::coord_t      coord_y;
    wnps_pkg::coord_t      coord_z;

    modport source (output valid, func, entry_index, coord_x, coord_y, coord_z,
                    input ready);
    modport sink   (input valid, func, entry_index, coord_x, coord_y, coord_z,
                    output ready);
endinterface

interface wnps_result_if;
    logic                  valid;
    logic                  ready;
    wnps_pkg::index_t      nearest_index;
    logic                  found;
    wnps_pkg::passes_t     window_passes;

    modport source (output valid, nearest_index, found, window_passes, input ready);
    modport sink   (input valid, nearest_index, found, window_passes, output ready);
endinterface

interface wnps_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [wnps_pkg::CFG_IDX_W-1:0]         index;
    logic [wnps_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/windowed_nearest_point_search_unit.sv =====
// ----------------------------------------------------------------------------
// Windowed nearest point search unit
// Stores up to MAX_POINTS points and answers nearest point queries.
//
// Channels: item (sink) carries loads (func 0) and queries (func 1); result
// (source) returns one word per query; cfg (sink) writes point_count,
// start_window and use_third_axis and is always ready; the user writes them
// only while idle, which the unit itself does not enforce. A load writes
// the point memory and gives no result. A query scans slots
// 0..count-1 once per window pass with one shared 32x32 squaring unit fed
// from a single-port point memory: each point is read and its axis distances
// taken; a point inside the window then has the three distances squared in
// turn and summed. A query takes at most 11 passes; with an empty table it
// goes straight to posting the result. item is not ready while a query runs.
// The result sits in an output register; a stalled receiver holds it there
// and the unit still takes new items; a query that finishes meanwhile waits
// for the register to free. Reset clears control state and registers to
// their reset values; the point memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "windowed_nearest_point_search_unit_macros.svh"

module windowed_nearest_point_search_unit #(
    parameter int MAX_POINTS = wnps_pkg::MAX_POINTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    wnps_item_if.sink          item,
    wnps_result_if.source      result,
    wnps_cfg_if.sink           cfg
);

    localparam int DEPTH = (MAX_POINTS < wnps_pkg::ADDR_SLOTS) ?
                           MAX_POINTS : wnps_pkg::ADDR_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = wnps_pkg::COUNT_W;
    localparam int WW    = wnps_pkg::WINDOW_W;
    localparam int DW    = wnps_pkg::DIST_W;
    localparam int MW    = 3 * wnps_pkg::COORD_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_Z,
        S_SUM,
        S_ADVANCE,
        S_RESULT
    } state_t;

    function automatic logic [DW-1:0] abs_diff(input logic [DW-1:0] a,
                                               input logic [DW-1:0] b);
        logic [DW:0] d;
        d = {a[DW-1], a} - {b[DW-1], b};
        abs_diff = d[DW] ? DW'(~d + 1'b1) : d[DW-1:0];
    endfunction

    state_t                       state_reg, state_next;
    logic [CW-1:0]                point_count_reg;
    logic [wnps_pkg::COORD_W-1:0] start_window_reg;
    logic                         use_z_reg;

    logic                         out_valid_reg, out_valid_next;
    wnps_pkg::index_t             out_index_reg, out_index_next;
    logic                         out_found_reg, out_found_next;
    wnps_pkg::passes_t            out_passes_reg, out_passes_next;

    logic                         hit_reg, hit_next;
    logic [CW-1:0]                j_reg, j_next;
    logic [WW-1:0]                window_reg, window_next;
    wnps_pkg::passes_t            passes_reg, passes_next;

    logic [DW-1:0]                qx_reg, qx_next, qy_reg, qy_next, qz_reg, qz_next;
    logic [DW-1:0]                dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [wnps_pkg::SQ_W-1:0]    prod_reg, prod_next;
    logic [wnps_pkg::SUM_W-1:0]   acc_reg, acc_next;
    logic [wnps_pkg::SUM_W-1:0]   best_reg, best_next;
    logic [AW-1:0]                best_idx_reg, best_idx_next;

    logic [MW-1:0]                mem [DEPTH];
    logic [MW-1:0]                rd_data_reg;

    logic                         item_acc;
    logic                         cfg_acc;
    logic [CW-1:0]                count_lim;
    logic [DW-1:0]                dx_c, dy_c, dz_c;
    logic                         in_window;
    logic [DW-1:0]                mul_op;
    logic [wnps_pkg::SQ_W-1:0]    sq;
    logic [wnps_pkg::SUM_W-1:0]   sum;
    logic [wnps_pkg::GROW_W-1:0]  grown;
    logic [CW-1:0]                j_inc;

    assign item.ready    = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign item_acc      = item.valid && item.ready;
    assign cfg_acc       = cfg.valid && cfg.ready;

    assign result.valid         = out_valid_reg;
    assign result.nearest_index = out_index_reg;
    assign result.found         = out_found_reg;
    assign result.window_passes = out_passes_reg;

    assign count_lim = (point_count_reg > CW'(DEPTH)) ? CW'(DEPTH) : point_count_reg;
    assign j_inc     = j_reg + CW'(1);

    // per-axis distances from the point word read last cycle
    assign dx_c = abs_diff(qx_reg, rd_data_reg[DW-1:0]);
    assign dy_c = abs_diff(qy_reg, rd_data_reg[2*DW-1:DW]);
    assign dz_c = use_z_reg ? abs_diff(qz_reg, rd_data_reg[3*DW-1:2*DW]) : '0;
    assign in_window = (WW'(dx_c) < window_reg) && (WW'(dy_c) < window_reg) &&
                       (WW'(dz_c) < window_reg);

    // shared squaring unit
    always_comb
    begin
        case (state_reg)
            S_SQ_Y:  mul_op = dy_reg;
            S_SQ_Z:  mul_op = dz_reg;
            default: mul_op = dx_reg;
        endcase
    end

    assign sq    = wnps_pkg::SQ_W'(mul_op) * wnps_pkg::SQ_W'(mul_op);
    assign sum   = acc_reg + wnps_pkg::SUM_W'(prod_reg);
    assign grown = {window_reg, 3'b000} + {2'b00, window_reg, 1'b0};

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_index_next  = out_index_reg;
        out_found_next  = out_found_reg;
        out_passes_next = out_passes_reg;
        hit_next        = hit_reg;
        j_next          = j_reg;
        window_next     = window_reg;
        passes_next     = passes_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        qz_next         = qz_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        dz_next         = dz_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc && item.func == wnps_pkg::FUNC_QUERY)
                begin
                    qx_next     = item.coord_x;
                    qy_next     = item.coord_y;
                    qz_next     = item.coord_z;
                    window_next = (start_window_reg == '0) ? WW'(1) : WW'(start_window_reg);
                    passes_next = '0;
                    hit_next    = 1'b0;
                    j_next      = '0;
                    state_next  = (count_lim == '0) ? S_RESULT : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                dx_next    = dx_c;
                dy_next    = dy_c;
                dz_next    = dz_c;
                state_next = in_window ? S_SQ_X : S_ADVANCE;
            end
            S_SQ_X:
            begin
                prod_next  = sq;
                state_next = S_SQ_Y;
            end
            S_SQ_Y:
            begin
                prod_next  = sq;
                acc_next   = wnps_pkg::SUM_W'(prod_reg);
                state_next = S_SQ_Z;
            end
            S_SQ_Z:
            begin
                prod_next  = sq;
                acc_next   = sum;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (!hit_reg || sum < best_reg)
                begin
                    hit_next      = 1'b1;
                    best_next     = sum;
                    best_idx_next = j_reg[AW-1:0];
                end
                state_next = S_ADVANCE;
            end
            S_ADVANCE:
            begin
                if (j_inc < count_lim)
                begin
                    j_next     = j_inc;
                    state_next = S_READ;
                end
                else if (hit_reg || window_reg >= wnps_pkg::WINDOW_SAT)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    window_next = (grown > wnps_pkg::GROW_W'(wnps_pkg::WINDOW_SAT)) ?
                                  wnps_pkg::WINDOW_SAT : WW'(grown);
                    passes_next = passes_reg + wnps_pkg::PASSES_W'(1);
                    j_next      = '0;
                    state_next  = S_READ;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = hit_reg;
                    out_index_next  = hit_reg ? wnps_pkg::INDEX_W'(best_idx_reg) : '0;
                    out_passes_next = hit_reg ? passes_reg : '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            hit_reg          <= 1'b0;
            point_count_reg  <= wnps_pkg::POINT_COUNT_RST;
            start_window_reg <= wnps_pkg::START_WINDOW_RST;
            use_z_reg        <= wnps_pkg::USE_THIRD_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            if (cfg_acc)
            begin
                unique case (cfg.index)
                    wnps_pkg::REG_POINT_COUNT:    point_count_reg  <= cfg.data[CW-1:0];
                    wnps_pkg::REG_START_WINDOW:   start_window_reg <= cfg.data;
                    wnps_pkg::REG_USE_THIRD_AXIS: use_z_reg        <= cfg.data[0];
                    default:                      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg  <= out_index_next;
        out_found_reg  <= out_found_next;
        out_passes_reg <= out_passes_next;
        j_reg          <= j_next;
        window_reg     <= window_next;
        passes_reg     <= passes_next;
        qx_reg         <= qx_next;
        qy_reg         <= qy_next;
        qz_reg         <= qz_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        dz_reg         <= dz_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
    end

    // point memory: write on load, read one slot per scan step
    always_ff @(posedge clk)
    begin
        if (item_acc && item.func == wnps_pkg::FUNC_LOAD &&
            {1'b0, item.entry_index} < CW'(DEPTH))
        begin
            mem[item.entry_index[AW-1:0]] <= {item.coord_z, item.coord_y, item.coord_x};
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            rd_data_reg <= mem[j_reg[AW-1:0]];
        end
    end

    `WNPS_ASSERT_IMP(a_not_found_zero, clk, rst_n,
        result.valid && !result.found,
        result.nearest_index == '0 && result.window_passes == '0,
        "not-found result carries nonzero index or passes")
    `WNPS_ASSERT_IMP(a_window_sat, clk, rst_n,
        state_reg != S_IDLE && state_reg != S_RESULT,
        window_reg <= wnps_pkg::WINDOW_SAT && window_reg != '0,
        "search window out of range")
    `WNPS_ASSERT_IMP(a_scan_in_range, clk, rst_n,
        state_reg == S_READ,
        j_reg < count_lim,
        "scan index beyond point count")
    `WNPS_ASSERT_IMP(a_best_in_range, clk, rst_n,
        hit_reg && state_reg == S_RESULT,
        CW'(best_idx_reg) < count_lim,
        "best index beyond point count")
    `WNPS_ASSERT_NXT(a_result_posted, clk, rst_n,
        state_reg == S_RESULT && (!out_valid_reg || result.ready),
        out_valid_reg && state_reg == S_IDLE,
        "finished query not posted")

endmodule

// ===== tb/windowed_nearest_point_search_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Windowed nearest point search unit: testbench
// Loads points and issues nearest point queries through the item channel,
// writes the registers through the cfg channel while the unit is idle, and
// compares every result word, field by field, with a behavioral model of the
// windowed search kept in the bench. Directed cases come first (empty table,
// ties, zero window, window growth up to saturation, planar mode, wide
// table), then random traffic under several idle and stall mixes, and a long
// receiver hold-off that backs the unit up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module windowed_nearest_point_search_unit_tb;

    localparam int                CYCLE_LIMIT   = 20_000_000;
    localparam int                LOAD_SETTLE   = 8;
    localparam int                WINDOW_GROWTH = 10;
    localparam int                HOLD_CYCLES   = 600;
    localparam int                WIDE_SLOTS    = 96;
    localparam wnps_pkg::coord_t  COORD_MIN     = 32'sh8000_0000;
    localparam wnps_pkg::coord_t  COORD_MAX     = 32'sh7FFF_FFFF;

    typedef struct packed {
        wnps_pkg::coord_t x;
        wnps_pkg::coord_t y;
        wnps_pkg::coord_t z;
    } point_t;

    typedef struct packed {
        wnps_pkg::index_t  nearest_index;
        logic              found;
        wnps_pkg::passes_t window_passes;
    } answer_t;

    logic clk;
    logic rst_n;

    wnps_item_if   item_ch ();
    wnps_result_if result_ch ();
    wnps_cfg_if    cfg_ch ();

    windowed_nearest_point_search_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    point_t                          stored_points [wnps_pkg::ADDR_SLOTS];
    logic [wnps_pkg::COUNT_W-1:0]    cur_count;
    logic [wnps_pkg::COORD_W-1:0]    cur_window;
    logic                            cur_third;
    answer_t                         pending_answers [$];

    int                    errors;
    int                    cycle_count;
    int                    idle_pct;
    int                    stall_pct;
    int                    hold_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: index %0d found %0b passes %0d", $time,
                         result_ch.nearest_index, result_ch.found, result_ch.window_passes);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (result_ch.nearest_index !== want.nearest_index)
                begin
                    errors++;
                    $display("%0t: nearest_index expected %0d actual %0d", $time,
                             want.nearest_index, result_ch.nearest_index);
                end
                if (result_ch.found !== want.found)
                begin
                    errors++;
                    $display("%0t: found expected %0b actual %0b", $time,
                             want.found, result_ch.found);
                end
                if (result_ch.window_passes !== want.window_passes)
                begin
                    errors++;
                    $display("%0t: window_passes expected %0d actual %0d", $time,
                             want.window_passes, result_ch.window_passes);
                end
            end
        end
    end

    function automatic logic [wnps_pkg::DIST_W-1:0] axis_gap(input wnps_pkg::coord_t a,
                                                             input wnps_pkg::coord_t b);
        logic [wnps_pkg::COORD_W:0] diff;
        diff = {a[wnps_pkg::COORD_W-1], a} - {b[wnps_pkg::COORD_W-1], b};
        if (diff[wnps_pkg::COORD_W])
            diff = -diff;
        return diff[wnps_pkg::DIST_W-1:0];
    endfunction

    function automatic answer_t nearest_answer(input point_t q);
        answer_t                        ans;
        int unsigned                    span;
        int unsigned                    j;
        int unsigned                    passes;
        logic                           hit;
        logic                           searching;
        logic [wnps_pkg::WINDOW_W-1:0]  window;
        logic [wnps_pkg::GROW_W-1:0]    grown;
        logic [wnps_pkg::DIST_W-1:0]    dx;
        logic [wnps_pkg::DIST_W-1:0]    dy;
        logic [wnps_pkg::DIST_W-1:0]    dz;
        logic [wnps_pkg::SUM_W-1:0]     sq;
        logic [wnps_pkg::SUM_W-1:0]     best_sq;
        ans = '0;
        span = (cur_count > wnps_pkg::ADDR_SLOTS) ? wnps_pkg::ADDR_SLOTS : cur_count;
        if (span == 0)
            return ans;
        window = (cur_window == '0) ? wnps_pkg::WINDOW_W'(1) : wnps_pkg::WINDOW_W'(cur_window);
        passes = 0;
        hit = 1'b0;
        best_sq = '0;
        searching = 1'b1;
        while (searching)
        begin
            for (j = 0; j < span; j++)
            begin
                dx = axis_gap(q.x, stored_points[j].x);
                dy = axis_gap(q.y, stored_points[j].y);
                dz = cur_third ? axis_gap(q.z, stored_points[j].z) : '0;
                if (dx < window && dy < window && dz < window)
                begin
                    sq = wnps_pkg::SUM_W'(dx) * wnps_pkg::SUM_W'(dx)
                       + wnps_pkg::SUM_W'(dy) * wnps_pkg::SUM_W'(dy)
                       + wnps_pkg::SUM_W'(dz) * wnps_pkg::SUM_W'(dz);
                    if (!hit || sq < best_sq)
                    begin
                        hit = 1'b1;
                        best_sq = sq;
                        ans.nearest_index = wnps_pkg::index_t'(j);
                    end
                end
            end
            if (hit || window >= wnps_pkg::WINDOW_SAT)
            begin
                searching = 1'b0;
            end
            else
            begin
                grown = wnps_pkg::GROW_W'(window) * wnps_pkg::GROW_W'(WINDOW_GROWTH);
                window = (grown > wnps_pkg::GROW_W'(wnps_pkg::WINDOW_SAT)) ?
                         wnps_pkg::WINDOW_SAT : grown[wnps_pkg::WINDOW_W-1:0];
                passes++;
            end
        end
        ans.found = hit;
        ans.window_passes = wnps_pkg::passes_t'(passes);
        return ans;
    endfunction

    function automatic wnps_pkg::coord_t jitter(input wnps_pkg::coord_t base);
        int unsigned      reach;
        logic [31:0]      step;
        reach = 1;
        repeat ($urandom_range(9))
            reach = reach * 10;
        step = $urandom_range(reach);
        return $urandom_range(1) ? wnps_pkg::coord_t'(base + step)
                                 : wnps_pkg::coord_t'(base - step);
    endfunction

    function automatic point_t near_point(input point_t base);
        point_t p;
        p.x = jitter(base.x);
        p.y = jitter(base.y);
        p.z = jitter(base.z);
        return p;
    endfunction

    function automatic point_t any_point();
        point_t p;
        p.x = $urandom;
        p.y = $urandom;
        p.z = $urandom;
        return p;
    endfunction

    task automatic send_word(input logic func, input wnps_pkg::index_t slot, input point_t p);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.func        <= func;
        item_ch.entry_index <= slot;
        item_ch.coord_x     <= p.x;
        item_ch.coord_y     <= p.y;
        item_ch.coord_z     <= p.z;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (func == wnps_pkg::FUNC_LOAD)
            stored_points[slot] = p;
        else
            pending_answers.push_back(nearest_answer(p));
    endtask

    task automatic query(input point_t p);
        send_word(wnps_pkg::FUNC_QUERY, wnps_pkg::index_t'($urandom), p);
    endtask

    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (LOAD_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input wnps_pkg::cfg_reg_t reg_sel,
                             input logic [wnps_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= reg_sel;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (reg_sel)
            wnps_pkg::REG_POINT_COUNT:    cur_count  = value[wnps_pkg::COUNT_W-1:0];
            wnps_pkg::REG_START_WINDOW:   cur_window = value;
            wnps_pkg::REG_USE_THIRD_AXIS: cur_third  = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_setting(input int unsigned count, input logic [31:0] window,
                                 input logic third);
        settle();
        write_reg(wnps_pkg::REG_POINT_COUNT, count);
        write_reg(wnps_pkg::REG_START_WINDOW, window);
        write_reg(wnps_pkg::REG_USE_THIRD_AXIS, {31'd0, third});
    endtask

    task automatic test_empty_table();
        query('{COORD_MAX, COORD_MIN, 32'sd0});
        query('{COORD_MIN, COORD_MAX, -32'sd1});
        settle();
    endtask

    task automatic test_exact_and_ties();
        send_word(wnps_pkg::FUNC_LOAD, 10'd0, '{32'sd0, 32'sd0, 32'sd0});
        send_word(wnps_pkg::FUNC_LOAD, 10'd1, '{COORD_MAX, COORD_MAX, COORD_MAX});
        send_word(wnps_pkg::FUNC_LOAD, 10'd2, '{COORD_MIN, COORD_MIN, COORD_MIN});
        send_word(wnps_pkg::FUNC_LOAD, 10'd3, '{32'sd0, 32'sd0, 32'sd0});
        send_word(wnps_pkg::FUNC_LOAD, 10'd4, '{32'sd5, -32'sd5, 32'sd1000});
        apply_setting(5, 32'd1, 1'b1);
        query('{32'sd0, 32'sd0, 32'sd0});
        query('{COORD_MIN, COORD_MIN, COORD_MIN});
        settle();
    endtask

    task automatic test_window_growth();
        query('{COORD_MIN, COORD_MAX, 32'sd0});
        query('{32'sd6, -32'sd4, 32'sd1000});
        settle();
        write_reg(wnps_pkg::REG_START_WINDOW, 32'd0);
        query('{32'sd1, 32'sd0, 32'sd0});
        query('{32'sd0, 32'sd0, 32'sd0});
        settle();
    endtask

    task automatic test_planar_mode();
        apply_setting(5, 32'hFFFF_FFFF, 1'b0);
        query('{32'sd5, -32'sd5, COORD_MIN});
        query('{32'sd0, 32'sd0, COORD_MAX});
        settle();
        write_reg(wnps_pkg::REG_USE_THIRD_AXIS, 32'd1);
        query('{32'sd5, -32'sd5, COORD_MIN});
        settle();
    endtask

    task automatic test_wide_table();
        int unsigned i;
        for (i = 0; i < WIDE_SLOTS; i++)
            send_word(wnps_pkg::FUNC_LOAD, wnps_pkg::index_t'(i), any_point());
        apply_setting(WIDE_SLOTS, wnps_pkg::START_WINDOW_RST, 1'b1);
        query(stored_points[WIDE_SLOTS-1]);
        query(near_point(stored_points[48]));
        query(any_point());
        apply_setting(WIDE_SLOTS, 32'd1, 1'b1);
        query(stored_points[77]);
        query(any_point());
        settle();
        write_reg(wnps_pkg::REG_USE_THIRD_AXIS, 32'd0);
        query(near_point(stored_points[90]));
        settle();
    endtask

    task automatic random_setting();
        int unsigned      count;
        logic [31:0]      window;
        int unsigned      reach;
        case ($urandom_range(9))
            0:       count = 0;
            1:       count = $urandom_range(64, 17);
            default: count = $urandom_range(16, 1);
        endcase
        case ($urandom_range(7))
            0: window = 32'd0;
            1: window = 32'd1;
            2: window = $urandom_range(100, 2);
            3:
            begin
                reach = 1;
                repeat ($urandom_range(9))
                    reach = reach * 10;
                window = reach;
            end
            4: window = $urandom;
            5: window = 32'hFFFF_FFFF;
            6: window = wnps_pkg::START_WINDOW_RST;
            default: window = $urandom_range(100000);
        endcase
        apply_setting(count, window, 1'(($urandom_range(1))));
    endtask

    task automatic test_random_traffic(input int send_gap_pct, input int hold_pct,
                                       input int n_items);
        int                  sent;
        int                  burst;
        int unsigned         span;
        wnps_pkg::index_t    slot;
        point_t              p;
        settle();
        idle_pct  = send_gap_pct;
        stall_pct = hold_pct;
        sent = 0;
        while (sent < n_items)
        begin
            random_setting();
            span = (cur_count > wnps_pkg::ADDR_SLOTS) ? wnps_pkg::ADDR_SLOTS : cur_count;
            burst = $urandom_range(36, 20);
            repeat (burst)
            begin
                if ($urandom_range(99) < 35)
                begin
                    slot = (span > 0 && $urandom_range(9) != 0)
                         ? wnps_pkg::index_t'($urandom_range(span - 1))
                         : wnps_pkg::index_t'($urandom);
                    p = (span > 0 && $urandom_range(3) != 0)
                      ? near_point(stored_points[$urandom_range(span - 1)]) : any_point();
                    send_word(wnps_pkg::FUNC_LOAD, slot, p);
                end
                else
                begin
                    p = (span > 0 && $urandom_range(6) != 0)
                      ? near_point(stored_points[$urandom_range(span - 1)]) : any_point();
                    query(p);
                end
            end
            sent += burst;
        end
        settle();
    endtask

    task automatic test_backpressure();
        apply_setting(4, 32'd1000, 1'b1);
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = HOLD_CYCLES;
        repeat (10)
            query(near_point(stored_points[$urandom_range(3)]));
        settle();
    endtask

    initial
    begin
        errors      = 0;
        cycle_count = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_left   = 0;
        cur_count   = wnps_pkg::POINT_COUNT_RST;
        cur_window  = wnps_pkg::START_WINDOW_RST;
        cur_third   = wnps_pkg::USE_THIRD_RST;
        rst_n               = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.func        = wnps_pkg::FUNC_LOAD;
        item_ch.entry_index = '0;
        item_ch.coord_x     = '0;
        item_ch.coord_y     = '0;
        item_ch.coord_z     = '0;
        result_ch.ready     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = wnps_pkg::REG_POINT_COUNT;
        cfg_ch.data         = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_table();
        test_exact_and_ties();
        test_window_growth();
        test_planar_mode();
        test_wide_table();
        test_random_traffic(0, 0, 100);
        test_random_traffic(63, 0, 100);
        test_backpressure();
        test_random_traffic(0, 63, 100);
        test_random_traffic(10, 10, 100);
        settle();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
